// ===== sv/hall_call_edge_fifo_unit_assert.svh =====
// assertion macros for the hall call queue
// no dependencies; the using module must have clk and rst_n in scope
`ifndef HALL_CALL_EDGE_FIFO_UNIT_ASSERT_SVH
`define HALL_CALL_EDGE_FIFO_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define HCEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define HCEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCEF_ASSERT(lbl, prop, msg)
`define HCEF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/hcef_pkg.sv =====
// shared constants and the controller command type for the hall call queue
// no dependencies
package hcef_pkg;

  localparam int FLOORS  = 16;
  localparam int PTR_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int CNT_W   = $clog2(FLOORS + 1);
  localparam int FLOOR_W = 4;
  localparam int ENTRY_W = FLOOR_W + 1;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic load;   // capture the accepted input transaction
    logic exec;   // apply it to the queue and fill the result register
  } hcef_cmd_t;

endpackage

// ===== sv/hcef_ctrl.sv =====
// controller for the hall call queue: input capture and result handshake
// depends on hcef_pkg
module hcef_ctrl
  import hcef_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output hcef_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec_go;
  logic in_acc;

  // the captured item may run once the result register is free or draining
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) || exec_go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go && !in_acc) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign cmd.load   = in_acc;
  assign cmd.exec   = exec_go;

endmodule

// ===== sv/hcef_dpath.sv =====
// datapath for the hall call queue: edge stores, request fifo, result register
// depends on hcef_pkg
module hcef_dpath
  import hcef_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  hcef_cmd_t          cmd,
  input  logic               in_func,
  input  logic [FLOOR_W-1:0] in_floor_index,
  input  logic               in_up_level,
  input  logic               in_down_level,
  output logic               req_valid,
  output logic [FLOOR_W-1:0] req_floor,
  output logic               req_dir,
  output logic               drop_up,
  output logic               drop_down,
  output logic [COUNT_W-1:0] queue_count
);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FLOORS - 1)) ? '0 : p + 1'b1;
  endfunction

  // captured transaction
  logic               func_r;
  logic [FLOOR_W-1:0] floor_r;
  logic               up_r;
  logic               dn_r;

  // queue state
  logic [FLOORS-1:0]  prev_up_r;
  logic [FLOORS-1:0]  prev_dn_r;
  logic [ENTRY_W-1:0] fifo_r [FLOORS];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // result register
  logic               req_valid_r;
  logic [FLOOR_W-1:0] req_floor_r;
  logic               req_dir_r;
  logic               drop_up_r;
  logic               drop_dn_r;
  logic [COUNT_W-1:0] queue_count_r;

  logic               in_range;
  logic [PTR_W-1:0]   fidx;
  logic               edge_up, edge_dn;
  logic               push_up, push_dn;
  logic [CNT_W-1:0]   count_mid;
  logic [PTR_W-1:0]   tail_dn;
  logic               pop;
  logic [ENTRY_W-1:0] head_entry;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      floor_r <= in_floor_index;
      up_r    <= in_up_level;
      dn_r    <= in_down_level;
    end
  end

  assign in_range = (32'(floor_r) < FLOORS);
  assign fidx     = PTR_W'(floor_r);
  assign edge_up  = !func_r && in_range && up_r && !prev_up_r[fidx];
  assign edge_dn  = !func_r && in_range && dn_r && !prev_dn_r[fidx];

  // up request goes in first, so the down request sees the count after it
  assign push_up   = edge_up && (count_r < CNT_W'(FLOORS));
  assign count_mid = count_r + CNT_W'(push_up);
  assign push_dn   = edge_dn && (count_mid < CNT_W'(FLOORS));
  assign tail_dn   = push_up ? ptr_inc(tail_r) : tail_r;

  assign pop        = func_r && (count_r != '0);
  assign head_entry = fifo_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = count_r - 1'b1;
    end else begin
      tail_nxt  = push_dn ? ptr_inc(tail_dn) : tail_dn;
      count_nxt = count_mid + CNT_W'(push_dn);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (push_up) fifo_r[tail_r] <= {1'b0, floor_r};
      if (push_dn) fifo_r[tail_dn] <= {1'b1, floor_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_up_r <= '0;
      prev_dn_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
    end else if (cmd.exec) begin
      // stored level follows the button even when the request was dropped
      if (!func_r && in_range) begin
        prev_up_r[fidx] <= up_r;
        prev_dn_r[fidx] <= dn_r;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      req_valid_r   <= pop;
      req_floor_r   <= pop ? head_entry[FLOOR_W-1:0] : '0;
      req_dir_r     <= pop ? head_entry[FLOOR_W] : 1'b0;
      drop_up_r     <= edge_up && !push_up;
      drop_dn_r     <= edge_dn && !push_dn;
      queue_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign req_valid   = req_valid_r;
  assign req_floor   = req_floor_r;
  assign req_dir     = req_dir_r;
  assign drop_up     = drop_up_r;
  assign drop_down   = drop_dn_r;
  assign queue_count = queue_count_r;

endmodule

// ===== sv/hall_call_edge_fifo_unit.sv =====
// Hall call request queue. Each input transaction either samples one floor's
// up and down button levels (in_tuser = 0) or takes the oldest request
// (in_tuser = 1). A rising button level queues a (floor, direction) request,
// up before down; a full queue drops the request and flags it. Every input
// transaction gives one result transaction: it is captured, then applied to
// the queue and result register. With out_tready held high the unit sustains
// one transaction per cycle, as the edge stores, fifo write and pointer
// update happen together. A held result register stalls the next update,
// and in turn in_tready. Queue depth and floor count are hcef_pkg::FLOORS.
// depends on hcef_pkg, hcef_ctrl, hcef_dpath and the assertion header
`include "hall_call_edge_fifo_unit_assert.svh"

module hall_call_edge_fifo_unit
  import hcef_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // floor_index[3:0], up_level[4], down_level[5], zero[7:6]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // req_floor[3:0], req_dir[4], drop_up[5], drop_down[6],
                                  // queue_count[11:7], zero[15:12]
  output logic        out_tuser   // req_valid[0]
);

  hcef_cmd_t          cmd;
  logic               req_valid;
  logic [FLOOR_W-1:0] req_floor;
  logic               req_dir;
  logic               drop_up;
  logic               drop_down;
  logic [COUNT_W-1:0] queue_count;

  hcef_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  hcef_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_func        (in_tuser),
    .in_floor_index (in_tdata[3:0]),
    .in_up_level    (in_tdata[4]),
    .in_down_level  (in_tdata[5]),
    .req_valid      (req_valid),
    .req_floor      (req_floor),
    .req_dir        (req_dir),
    .drop_up        (drop_up),
    .drop_down      (drop_down),
    .queue_count    (queue_count)
  );

  assign out_tdata = {4'b0000, queue_count, drop_down, drop_up, req_dir, req_floor};
  assign out_tuser = req_valid;

  `HCEF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `HCEF_ASSERT(a_empty_take_clean, (out_tvalid && !out_tuser) |-> (out_tdata[4:0] == 5'd0),
               "floor or direction set without a taken request")
  `HCEF_ASSERT(a_take_no_drop, (out_tvalid && out_tuser) |-> (!out_tdata[5] && !out_tdata[6]),
               "drop flag on a take transaction")
  `HCEF_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)),
               "result changed while stalled")

endmodule

// ===== tb/hall_call_edge_fifo_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for hall_call_edge_fifo_unit: button samples and takes are
// streamed in and every result is checked against a queue model kept in a scoreboard class
// depends on hcef_pkg and the hall_call_edge_fifo_unit rtl
module hall_call_edge_fifo_unit_test;
  import hcef_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TAKE   = 1'b1;
  localparam logic DIR_UP      = 1'b0;
  localparam logic DIR_DOWN    = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   HOLD_CYCLES = 80;
  localparam int   PHASE_ITEMS = 150;

  typedef struct {
    logic                req_valid;
    logic [FLOOR_W-1:0]  req_floor;
    logic                req_dir;
    logic                drop_up;
    logic                drop_down;
    logic [COUNT_W-1:0]  queue_count;
  } hall_result_t;

  class hall_call_board;
    logic               up_seen[FLOORS];
    logic               down_seen[FLOORS];
    logic [ENTRY_W-1:0] slots[FLOORS];
    int                 head;
    int                 tail;
    int                 count;
    int                 errors;
    hall_result_t       awaited[$];

    function new();
      foreach (up_seen[i]) begin
        up_seen[i]   = 1'b0;
        down_seen[i] = 1'b0;
        slots[i]     = '0;
      end
      head   = 0;
      tail   = 0;
      count  = 0;
      errors = 0;
    endfunction

    // returns 1 when the request is lost to a full queue
    function logic enqueue(logic [FLOOR_W-1:0] floor, logic dir);
      if (count >= FLOORS) return 1'b1;
      slots[tail] = {dir, floor};
      tail = (tail + 1) % FLOORS;
      count++;
      return 1'b0;
    endfunction

    function void note_input(logic [7:0] tdata, logic tuser);
      hall_result_t       r;
      logic [FLOOR_W-1:0] floor;
      logic               up;
      logic               down;
      floor = tdata[3:0];
      up    = tdata[4];
      down  = tdata[5];
      r.req_valid = 1'b0;
      r.req_floor = '0;
      r.req_dir   = 1'b0;
      r.drop_up   = 1'b0;
      r.drop_down = 1'b0;
      if (tuser == FUNC_SAMPLE) begin
        if (up && !up_seen[floor]) r.drop_up = enqueue(floor, DIR_UP);
        if (down && !down_seen[floor]) r.drop_down = enqueue(floor, DIR_DOWN);
        // levels are stored even when the request was dropped
        up_seen[floor]   = up;
        down_seen[floor] = down;
      end else if (count > 0) begin
        r.req_valid = 1'b1;
        r.req_floor = slots[head][FLOOR_W-1:0];
        r.req_dir   = slots[head][FLOOR_W];
        head = (head + 1) % FLOORS;
        count--;
      end
      r.queue_count = count[COUNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_result(logic [15:0] tdata, logic tuser);
      hall_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, tdata, tuser);
        return;
      end
      e = awaited.pop_front();
      compare_field("req_valid", int'(e.req_valid), int'(tuser));
      compare_field("req_floor", int'(e.req_floor), int'(tdata[3:0]));
      compare_field("req_dir", int'(e.req_dir), int'(tdata[4]));
      compare_field("drop_up", int'(e.drop_up), int'(tdata[5]));
      compare_field("drop_down", int'(e.drop_down), int'(tdata[6]));
      compare_field("queue_count", int'(e.queue_count), int'(tdata[11:7]));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  hall_call_board board;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int cycle_count;

  hall_call_edge_fifo_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hall_call_edge_fifo_unit_test: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // input transactions are predicted before results are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    end
  end

  task automatic send_item(input logic func_bit, input logic [3:0] floor, input logic up,
                           input logic down);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, down, up, floor};
    in_tuser  <= func_bit;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(FUNC_TAKE, 4'd0, 1'b0, 1'b0);      // take from an empty queue
    send_item(FUNC_SAMPLE, 4'd0, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, 4'd15, 1'b1, 1'b1);
    send_item(FUNC_SAMPLE, 4'd15, 1'b1, 1'b1);   // held buttons, no new requests
    send_item(FUNC_SAMPLE, 4'd15, 1'b0, 1'b0);
    repeat (4) send_item(FUNC_TAKE, 4'd15, 1'b1, 1'b1);
    for (int f = 1; f <= 7; f++) send_item(FUNC_SAMPLE, f[3:0], 1'b1, 1'b1);
    send_item(FUNC_SAMPLE, 4'd8, 1'b1, 1'b0);
    send_item(FUNC_SAMPLE, 4'd9, 1'b1, 1'b1);    // one slot free: up queued, down dropped
    send_item(FUNC_SAMPLE, 4'd10, 1'b1, 1'b1);   // full: both dropped
    send_item(FUNC_TAKE, 4'd0, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 4'd9, 1'b0, 1'b0);
    send_item(FUNC_SAMPLE, 4'd9, 1'b0, 1'b1);
    send_item(FUNC_TAKE, 4'd0, 1'b0, 1'b0);
  endtask

  // bursts that mostly fill, mostly drain or mix, so the queue swings between ends
  task automatic run_random(input int items);
    int sent;
    int mode;
    int span;
    int take_pct;
    sent = 0;
    while (sent < items) begin
      mode = $urandom_range(2);
      span = $urandom_range(30, 8);
      take_pct = (mode == 0) ? 15 : (mode == 1) ? 80 : 45;
      repeat (span) begin
        if ($urandom_range(99) < take_pct)
          send_item(FUNC_TAKE, 4'($urandom_range(15)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        else
          send_item(FUNC_SAMPLE, 4'($urandom_range(15)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    int idle_table[4];
    int stall_table[4];
    idle_table  = '{0, 63, 0, 26};
    stall_table = '{0, 0, 63, 26};
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks = 0;
    hold_seen = 0;
    hold_left = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_table[p];
      recv_stall_pct = stall_table[p];
      // long receiver hold-off while the sender keeps offering, so input backs up
      if (p == 0) hold_asks++;
      run_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("hall_call_edge_fifo_unit_test: done, clean");
    else
      $display("hall_call_edge_fifo_unit_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hcef_pkg.sv
sv/hcef_ctrl.sv
sv/hcef_dpath.sv
sv/hall_call_edge_fifo_unit.sv
tb/hall_call_edge_fifo_unit_test.sv
